// ===== rtl/greedy_activity_selector_assert.svh =====
// Assertion macros used by the greedy activity selector checker.
`ifndef GREEDY_ACTIVITY_SELECTOR_ASSERT_SVH
`define GREEDY_ACTIVITY_SELECTOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define GAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define GAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gas_pkg.sv =====
// Types and constants of the greedy activity selector.
package gas_pkg;

  localparam int unsigned IdBits    = 16;
  localparam int unsigned FieldBits = 16;

  typedef struct packed {
    logic [IdBits-1:0]    activity_id;
    logic [FieldBits-1:0] activity_start;
    logic [FieldBits-1:0] activity_finish;
    logic                 set_end;
  } in_item_t;

  typedef struct packed {
    logic [IdBits-1:0] chosen_id;
    logic              run_end;
    logic              overflowed;
  } out_item_t;

  // Command that the controller broadcasts to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic scan;
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

endpackage

// ===== rtl/gas_cell.sv =====
// One cell of the sorted activity chain: holds an entry, shifts right on insert, left on scan.
module gas_cell
  import gas_pkg::*;
#(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_op_t             op_i,
  input  logic [IdBits-1:0]    new_id_i,
  input  logic [TIME_BITS-1:0] new_start_i,
  input  logic [TIME_BITS-1:0] new_finish_i,
  input  logic                 left_shift_i,
  input  logic                 left_valid_i,
  input  logic [IdBits-1:0]    left_id_i,
  input  logic [TIME_BITS-1:0] left_start_i,
  input  logic [TIME_BITS-1:0] left_finish_i,
  input  logic                 right_valid_i,
  input  logic [IdBits-1:0]    right_id_i,
  input  logic [TIME_BITS-1:0] right_start_i,
  input  logic [TIME_BITS-1:0] right_finish_i,
  output logic                 shift_o,
  output logic                 valid_o,
  output logic [IdBits-1:0]    id_o,
  output logic [TIME_BITS-1:0] start_o,
  output logic [TIME_BITS-1:0] finish_o
);

  logic                 valid_q, valid_d;
  logic [IdBits-1:0]    id_q, id_d;
  logic [TIME_BITS-1:0] start_q, start_d;
  logic [TIME_BITS-1:0] finish_q, finish_d;
  logic                 new_below;

  // The chain is kept in descending key order from cell 0. A new entry sits in
  // front of every entry whose key is not greater, so equal keys put the later
  // arrival nearer the head.
  assign new_below = (new_start_i < start_q) ||
                     ((new_start_i == start_q) && (new_finish_i < finish_q));
  assign shift_o   = !valid_q || !new_below;

  always_comb begin
    valid_d  = valid_q;
    id_d     = id_q;
    start_d  = start_q;
    finish_d = finish_q;
    if (op_i.insert && shift_o) begin
      if (left_shift_i) begin
        valid_d  = left_valid_i;
        id_d     = left_id_i;
        start_d  = left_start_i;
        finish_d = left_finish_i;
      end else begin
        valid_d  = 1'b1;
        id_d     = new_id_i;
        start_d  = new_start_i;
        finish_d = new_finish_i;
      end
    end else if (op_i.scan) begin
      valid_d  = right_valid_i;
      id_d     = right_id_i;
      start_d  = right_start_i;
      finish_d = right_finish_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q     <= id_d;
    start_q  <= start_d;
    finish_q <= finish_d;
  end

  assign valid_o  = valid_q;
  assign id_o     = id_q;
  assign start_o  = start_q;
  assign finish_o = finish_q;

endmodule

// ===== rtl/greedy_activity_selector.sv =====
// Greedy activity selector: sorted cell chain with a backward selection scan.
//
// Input channel (in_valid_i/in_ready_o, in_item_i) takes one activity per cycle
// while loading. Each item is inserted into a chain of MAX_ACTIVITIES cells that
// keeps the set sorted by start, then finish, equal keys by arrival. Items that
// arrive with the chain full are dropped and flag the set as overflowed.
// An item with set_end high ends loading; in_ready_o then stays low while the
// chain shifts its entries, highest first, past the selection logic at one
// entry per cycle until a stalled receiver holds it. Selected ids leave through
// an output register (out_valid_o/out_ready_i, out_item_o). One selected id is
// held back until the next is found, so the last one can carry run_end. A
// stalled receiver holds the scan at the next selected entry while a result
// waits to be handed over; loading of the next set may begin while the final
// result still waits. Reset empties the chain and clears the overflow flag.
module greedy_activity_selector
  import gas_pkg::*;
#(
  parameter int unsigned MAX_ACTIVITIES = 64,
  parameter int unsigned TIME_BITS      = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  state_e               state_q, state_d;
  logic                 overflow_q, overflow_d;
  logic                 pend_valid_q, pend_valid_d;
  logic [IdBits-1:0]    pend_id_q, pend_id_d;
  logic [TIME_BITS-1:0] last_start_q, last_start_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_item_q, out_item_d;

  cell_op_t             op;
  logic                 accept;
  logic                 full;
  logic [31:0]          start_wide, finish_wide;
  logic [TIME_BITS-1:0] new_start, new_finish;
  logic                 out_free;
  logic                 qualifies;

  logic                 cell_shift  [MAX_ACTIVITIES];
  logic                 cell_valid  [MAX_ACTIVITIES];
  logic [IdBits-1:0]    cell_id     [MAX_ACTIVITIES];
  logic [TIME_BITS-1:0] cell_start  [MAX_ACTIVITIES];
  logic [TIME_BITS-1:0] cell_finish [MAX_ACTIVITIES];

  // Only the low TIME_BITS bits of the times take part.
  assign start_wide  = 32'(in_item_i.activity_start);
  assign finish_wide = 32'(in_item_i.activity_finish);
  assign new_start   = start_wide[TIME_BITS-1:0];
  assign new_finish  = finish_wide[TIME_BITS-1:0];

  assign in_ready_o = (state_q == ST_LOAD);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = cell_valid[MAX_ACTIVITIES-1];
  assign out_free   = !out_valid_q || out_ready_i;
  assign qualifies  = !pend_valid_q || (cell_finish[0] <= last_start_q);

  for (genvar i = 0; i < MAX_ACTIVITIES; i++) begin : g_cell
    logic                 l_shift, l_valid, r_valid;
    logic [IdBits-1:0]    l_id, r_id;
    logic [TIME_BITS-1:0] l_start, l_finish, r_start, r_finish;

    if (i == 0) begin : g_head
      assign l_shift  = 1'b0;
      assign l_valid  = 1'b0;
      assign l_id     = in_item_i.activity_id;
      assign l_start  = new_start;
      assign l_finish = new_finish;
    end else begin : g_body
      assign l_shift  = cell_shift[i-1];
      assign l_valid  = cell_valid[i-1];
      assign l_id     = cell_id[i-1];
      assign l_start  = cell_start[i-1];
      assign l_finish = cell_finish[i-1];
    end

    if (i == MAX_ACTIVITIES - 1) begin : g_tail
      assign r_valid  = 1'b0;
      assign r_id     = '0;
      assign r_start  = '0;
      assign r_finish = '0;
    end else begin : g_inner
      assign r_valid  = cell_valid[i+1];
      assign r_id     = cell_id[i+1];
      assign r_start  = cell_start[i+1];
      assign r_finish = cell_finish[i+1];
    end

    gas_cell #(
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .op_i          (op),
      .new_id_i      (in_item_i.activity_id),
      .new_start_i   (new_start),
      .new_finish_i  (new_finish),
      .left_shift_i  (l_shift),
      .left_valid_i  (l_valid),
      .left_id_i     (l_id),
      .left_start_i  (l_start),
      .left_finish_i (l_finish),
      .right_valid_i (r_valid),
      .right_id_i    (r_id),
      .right_start_i (r_start),
      .right_finish_i(r_finish),
      .shift_o       (cell_shift[i]),
      .valid_o       (cell_valid[i]),
      .id_o          (cell_id[i]),
      .start_o       (cell_start[i]),
      .finish_o      (cell_finish[i])
    );
  end

  always_comb begin
    state_d      = state_q;
    overflow_d   = overflow_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    last_start_d = last_start_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_item_d   = out_item_q;
    op           = '0;

    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (full) begin
            overflow_d = 1'b1;
          end else begin
            op.insert = 1'b1;
          end
          if (in_item_i.set_end) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (cell_valid[0]) begin
          if (!qualifies) begin
            op.scan = 1'b1;
          end else if (!pend_valid_q || out_free) begin
            // The held id is known not to be the last one once another is chosen.
            op.scan = 1'b1;
            if (pend_valid_q) begin
              out_valid_d           = 1'b1;
              out_item_d.chosen_id  = pend_id_q;
              out_item_d.run_end    = 1'b0;
              out_item_d.overflowed = overflow_q;
            end
            pend_valid_d = 1'b1;
            pend_id_d    = cell_id[0];
            last_start_d = cell_start[0];
          end
        end else if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_valid_d           = 1'b1;
            out_item_d.chosen_id  = pend_id_q;
            out_item_d.run_end    = 1'b1;
            out_item_d.overflowed = overflow_q;
          end
          pend_valid_d = 1'b0;
          overflow_d   = 1'b0;
          last_start_d = '0;
          state_d      = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      overflow_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      last_start_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      overflow_q   <= overflow_d;
      pend_valid_q <= pend_valid_d;
      last_start_q <= last_start_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q  <= pend_id_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/gas_checker.sv =====
// Port-level assertions for the greedy activity selector, bound to the top level.
`include "greedy_activity_selector_assert.svh"

module gas_checker
  import gas_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  `GAS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result item dropped while stalled")
  `GAS_ASSERT_NEXT(a_scan_after_end, in_valid_i && in_ready_o && in_item_i.set_end, !in_ready_o, "input still open after the last item of a set")
  `GAS_ASSERT_NEXT(a_load_continues, in_valid_i && in_ready_o && !in_item_i.set_end, in_ready_o, "input closed in the middle of a set")
  `GAS_ASSERT_NOW(a_mid_run_closed, out_valid_o && !out_item_o.run_end, !in_ready_o, "input open while a selection run is in progress")

endmodule

bind greedy_activity_selector gas_checker u_gas_checker (.*);
